// ===== rtl/hrsd_pkg.sv =====
// Shared types, codes and constants for the heater run-state supervisor.
package hrsd_pkg;

    // Field widths
    localparam int TIME_W    = 32;
    localparam int TEMP_W    = 16;
    localparam int STATE_W   = 3;
    localparam int MODE_W    = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 72;
    localparam int OUT_W     = 24;

    // Run state codes
    localparam logic [STATE_W-1:0] ST_BOOT    = 3'd0;
    localparam logic [STATE_W-1:0] ST_IDLE    = 3'd1;
    localparam logic [STATE_W-1:0] ST_CAL     = 3'd2;
    localparam logic [STATE_W-1:0] ST_NOCAL   = 3'd3;
    localparam logic [STATE_W-1:0] ST_STANDBY = 3'd4;
    localparam logic [STATE_W-1:0] ST_HEATING = 3'd5;
    localparam logic [STATE_W-1:0] ST_READY   = 3'd6;
    localparam logic [STATE_W-1:0] ST_FAULT   = 3'd7;

    // Heat mode codes
    localparam logic [MODE_W-1:0] MD_IDLE     = 3'd0;
    localparam logic [MODE_W-1:0] MD_CAL      = 3'd1;
    localparam logic [MODE_W-1:0] MD_STANDBY  = 3'd2;
    localparam logic [MODE_W-1:0] MD_HEATUP   = 3'd3;
    localparam logic [MODE_W-1:0] MD_COOLDOWN = 3'd4;
    localparam logic [MODE_W-1:0] MD_HOLD     = 3'd5;
    localparam logic [MODE_W-1:0] MD_FAULT    = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_ENTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_EXIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_ENTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_EXIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STANDBY    = 3'd5;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_HEAT_ENTER = 16'd90;
    localparam logic [CFG_W-1:0] RST_HEAT_EXIT  = 16'd20;
    localparam logic [CFG_W-1:0] RST_COOL_ENTER = 16'd120;
    localparam logic [CFG_W-1:0] RST_COOL_EXIT  = 16'd40;
    localparam logic [CFG_W-1:0] RST_DEBOUNCE   = 16'd500;
    localparam logic [CFG_W-1:0] RST_STANDBY    = 16'd1800;

    // Configuration register set
    typedef struct packed {
        logic [CFG_W-1:0] heat_enter_band;
        logic [CFG_W-1:0] heat_exit_band;
        logic [CFG_W-1:0] cool_enter_band;
        logic [CFG_W-1:0] cool_exit_band;
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] standby_target;
    } cfg_t;

    // One supervisor tick
    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [TEMP_W-1:0] tip_temp;
        logic [TEMP_W-1:0] user_target;
        logic              is_docked;
        logic              cal_valid;
        logic              cal_session;
        logic              heater_present;
        logic              fault_active;
        logic              ack_request;
    } item_t;

    // Supervisor state
    typedef struct packed {
        logic [STATE_W-1:0] current_state;
        logic [MODE_W-1:0]  current_mode;
        logic [STATE_W-1:0] pending_state;
        logic [MODE_W-1:0]  pending_mode;
        logic [TIME_W-1:0]  pending_since;
        logic               fault_latched;
    } state_t;

    // One result
    typedef struct packed {
        logic [STATE_W-1:0] run_state;
        logic [MODE_W-1:0]  heat_mode;
        logic [TEMP_W-1:0]  effective_target;
        logic               standby_on;
        logic               ack_accepted;
    } result_t;

endpackage

// ===== rtl/hrsd_cfg.sv =====
// Configuration register file for the heater run-state supervisor.
module hrsd_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hrsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hrsd_pkg::CFG_W-1:0]     cfg_data,
    output hrsd_pkg::cfg_t                 cfg
);

    hrsd_pkg::cfg_t cfg_reg;

    // Register writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heat_enter_band <= hrsd_pkg::RST_HEAT_ENTER;
            cfg_reg.heat_exit_band  <= hrsd_pkg::RST_HEAT_EXIT;
            cfg_reg.cool_enter_band <= hrsd_pkg::RST_COOL_ENTER;
            cfg_reg.cool_exit_band  <= hrsd_pkg::RST_COOL_EXIT;
            cfg_reg.debounce_time   <= hrsd_pkg::RST_DEBOUNCE;
            cfg_reg.standby_target  <= hrsd_pkg::RST_STANDBY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hrsd_pkg::REG_HEAT_ENTER: cfg_reg.heat_enter_band <= cfg_data;
                hrsd_pkg::REG_HEAT_EXIT:  cfg_reg.heat_exit_band  <= cfg_data;
                hrsd_pkg::REG_COOL_ENTER: cfg_reg.cool_enter_band <= cfg_data;
                hrsd_pkg::REG_COOL_EXIT:  cfg_reg.cool_exit_band  <= cfg_data;
                hrsd_pkg::REG_DEBOUNCE:   cfg_reg.debounce_time   <= cfg_data;
                hrsd_pkg::REG_STANDBY:    cfg_reg.standby_target  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/hrsd_core.sv =====
// Decision logic: target selection, hysteresis, debounce and fault latch.
module hrsd_core
(
    input  hrsd_pkg::cfg_t    cfg,
    input  hrsd_pkg::item_t   item,
    input  hrsd_pkg::state_t  state,
    output hrsd_pkg::state_t  state_next,
    output hrsd_pkg::result_t result
);

    localparam int CMP_W = hrsd_pkg::TEMP_W + 1;

    logic [hrsd_pkg::TEMP_W-1:0]  target;
    logic                         standby_on;
    logic                         ack_ok;
    hrsd_pkg::state_t             st1;
    logic                         latch;
    logic [hrsd_pkg::MODE_W-1:0]  rest_mode;
    logic                         continuing;
    logic [CMP_W-1:0]             tip_w;
    logic [CMP_W-1:0]             tgt_w;
    logic                         below_exit;
    logic                         below_enter;
    logic                         above_exit;
    logic                         above_enter;
    logic [hrsd_pkg::MODE_W-1:0]  dmd;
    logic [hrsd_pkg::STATE_W-1:0] dst;
    logic [hrsd_pkg::TIME_W-1:0]  elapsed;
    logic                         take_now;
    logic                         differs;

    // Target in use
    always_comb
    begin
        standby_on = 1'b0;
        if (!item.heater_present)
        begin
            target = cfg.standby_target;
        end
        else if (item.is_docked)
        begin
            target     = cfg.standby_target;
            standby_on = 1'b1;
        end
        else
        begin
            target = item.user_target;
        end
    end

    // An acknowledge with no fault active clears the latch and drops to idle before anything else
    assign ack_ok = item.ack_request && !item.fault_active;

    always_comb
    begin
        st1 = state;
        if (ack_ok)
        begin
            st1.current_state = hrsd_pkg::ST_IDLE;
            st1.current_mode  = hrsd_pkg::MD_IDLE;
            st1.pending_state = hrsd_pkg::ST_IDLE;
            st1.pending_mode  = hrsd_pkg::MD_IDLE;
            st1.pending_since = item.time_ms;
            st1.fault_latched = 1'b0;
        end
        st1.fault_latched = st1.fault_latched | item.fault_active;
    end

    assign latch = st1.fault_latched || (st1.current_state == hrsd_pkg::ST_FAULT);

    // Hysteresis compares, one bit wider so band plus value never wraps
    assign tip_w       = {1'b0, item.tip_temp};
    assign tgt_w       = {1'b0, target};
    assign below_exit  = (tip_w + {1'b0, cfg.heat_exit_band}) < tgt_w;
    assign below_enter = (tip_w + {1'b0, cfg.heat_enter_band}) < tgt_w;
    assign above_exit  = tip_w > (tgt_w + {1'b0, cfg.cool_exit_band});
    assign above_enter = tip_w > (tgt_w + {1'b0, cfg.cool_enter_band});

    assign rest_mode  = item.is_docked ? hrsd_pkg::MD_STANDBY : hrsd_pkg::MD_HOLD;
    assign continuing = (st1.current_mode == hrsd_pkg::MD_HEATUP)
                     || (item.is_docked  && st1.current_mode == hrsd_pkg::MD_STANDBY)
                     || (!item.is_docked && st1.current_mode == hrsd_pkg::MD_IDLE);

    // Desired mode
    always_comb
    begin
        priority if (continuing)
            dmd = below_exit ? hrsd_pkg::MD_HEATUP : rest_mode;
        else if (st1.current_mode == hrsd_pkg::MD_COOLDOWN)
            dmd = above_exit ? hrsd_pkg::MD_COOLDOWN : rest_mode;
        else if (below_enter)
            dmd = hrsd_pkg::MD_HEATUP;
        else if (above_enter)
            dmd = hrsd_pkg::MD_COOLDOWN;
        else
            dmd = rest_mode;
    end

    // Desired run state
    always_comb
    begin
        priority if (item.is_docked)
            dst = hrsd_pkg::ST_STANDBY;
        else if (dmd == hrsd_pkg::MD_HEATUP)
            dst = hrsd_pkg::ST_HEATING;
        else if (dmd == hrsd_pkg::MD_COOLDOWN)
            dst = hrsd_pkg::ST_IDLE;
        else
            dst = hrsd_pkg::ST_READY;
    end

    // Debounce timing on wrapping time
    assign elapsed  = item.time_ms - st1.pending_since;
    assign take_now = (st1.current_state == hrsd_pkg::ST_BOOT)
                   || (dst == st1.current_state && dmd == st1.current_mode);
    assign differs  = (dst != st1.pending_state) || (dmd != st1.pending_mode);

    // Next state
    always_comb
    begin
        state_next = st1;
        priority if (latch)
        begin
            state_next.current_state = hrsd_pkg::ST_FAULT;
            state_next.current_mode  = hrsd_pkg::MD_FAULT;
        end
        else if (!item.heater_present)
        begin
            state_next.current_state = hrsd_pkg::ST_IDLE;
            state_next.current_mode  = hrsd_pkg::MD_IDLE;
        end
        else if (item.cal_session)
        begin
            state_next.current_state = hrsd_pkg::ST_CAL;
            state_next.current_mode  = hrsd_pkg::MD_CAL;
            state_next.pending_state = hrsd_pkg::ST_CAL;
            state_next.pending_mode  = hrsd_pkg::MD_CAL;
            state_next.pending_since = item.time_ms;
        end
        else if (!item.cal_valid)
        begin
            if (item.is_docked)
            begin
                state_next.current_state = hrsd_pkg::ST_STANDBY;
                state_next.current_mode  = hrsd_pkg::MD_STANDBY;
                state_next.pending_state = hrsd_pkg::ST_STANDBY;
                state_next.pending_mode  = hrsd_pkg::MD_STANDBY;
            end
            else
            begin
                state_next.current_state = hrsd_pkg::ST_NOCAL;
                state_next.current_mode  = hrsd_pkg::MD_IDLE;
                state_next.pending_state = hrsd_pkg::ST_NOCAL;
                state_next.pending_mode  = hrsd_pkg::MD_IDLE;
            end
            state_next.pending_since = item.time_ms;
        end
        else if (take_now)
        begin
            state_next.current_state = dst;
            state_next.current_mode  = dmd;
            state_next.pending_state = dst;
            state_next.pending_mode  = dmd;
            state_next.pending_since = item.time_ms;
        end
        else if (differs)
        begin
            state_next.pending_state = dst;
            state_next.pending_mode  = dmd;
            state_next.pending_since = item.time_ms;
        end
        else if (elapsed >= {{(hrsd_pkg::TIME_W-hrsd_pkg::CFG_W){1'b0}}, cfg.debounce_time})
        begin
            state_next.current_state = dst;
            state_next.current_mode  = dmd;
        end
        else
        begin
            state_next.current_state = st1.current_state;
        end
    end

    // Result fields
    assign result.run_state        = state_next.current_state;
    assign result.heat_mode        = state_next.current_mode;
    assign result.effective_target = target;
    assign result.standby_on       = standby_on;
    assign result.ack_accepted     = ack_ok;

endmodule

// ===== rtl/heater_run_state_debounced_mode.sv =====
// Top level of the heater run-state supervisor: input register, state and result register.
//
// One item on the slave stream is one supervisor tick; one item on the master
// stream is the run state, heat mode and target decided for that tick.
// Ticks are processed strictly in order, each seeing the state left by the one
// before it. Configuration writes (cfg_we, cfg_index, cfg_data) set the
// hysteresis bands, debounce time and standby target; write only while idle.
//
// A tick accepted into the input register is decided by the combinational core,
// written to the result register once that register is free or being taken,
// and is then offered on the master side.
// Throughput: one tick per cycle while m_tready is high, set by the combinational
// decision logic between the input register and the result register.
// Stall: while m_tready is low the result holds; one further tick is taken
// into the input register, then s_tready drops until the result is taken.
// Reset: state returns to boot/idle with no pending change and the fault
// latch clear; configuration returns to its defaults; both streams empty.
module heater_run_state_debounced_mode
(
    input  logic                           clk,
    input  logic                           rst_n,
    // slave: time_ms[31:0], tip_temp[47:32], user_target[63:48], is_docked[64],
    //        cal_valid[65], cal_session[66], heater_present[67], fault_active[68],
    //        ack_request[69], zero pad[71:70]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hrsd_pkg::IN_W-1:0]      s_tdata,
    // master: run_state[2:0], heat_mode[5:3], effective_target[21:6],
    //         standby_on[22], ack_accepted[23]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hrsd_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           cfg_we,
    input  logic [hrsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hrsd_pkg::CFG_W-1:0]     cfg_data
);

    hrsd_pkg::cfg_t    cfg;
    hrsd_pkg::item_t   item;
    hrsd_pkg::state_t  state_reg;
    hrsd_pkg::state_t  state_next;
    hrsd_pkg::result_t result;

    logic                      in_valid_reg;
    logic [hrsd_pkg::IN_W-1:0] in_data_reg;
    logic                      out_valid_reg;
    hrsd_pkg::result_t         out_data_reg;
    logic                      advance;

    hrsd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
    end

    // Unpack the tick fields
    assign item.time_ms        = in_data_reg[31:0];
    assign item.tip_temp       = in_data_reg[47:32];
    assign item.user_target    = in_data_reg[63:48];
    assign item.is_docked      = in_data_reg[64];
    assign item.cal_valid      = in_data_reg[65];
    assign item.cal_session    = in_data_reg[66];
    assign item.heater_present = in_data_reg[67];
    assign item.fault_active   = in_data_reg[68];
    assign item.ack_request    = in_data_reg[69];

    hrsd_core u_core
    (
        .cfg        (cfg),
        .item       (item),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Supervisor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.current_state <= hrsd_pkg::ST_BOOT;
            state_reg.current_mode  <= hrsd_pkg::MD_IDLE;
            state_reg.pending_state <= hrsd_pkg::ST_BOOT;
            state_reg.pending_mode  <= hrsd_pkg::MD_IDLE;
            state_reg.pending_since <= '0;
            state_reg.fault_latched <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.ack_accepted, out_data_reg.standby_on,
                       out_data_reg.effective_target, out_data_reg.heat_mode,
                       out_data_reg.run_state};

`ifndef ASSERT_OFF
    // A latched fault always shows as the fault state in the result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_next.fault_latched |=>
            out_data_reg.run_state == hrsd_pkg::ST_FAULT)
        else $error("latched fault not reported");

    // An accepted acknowledge never leaves the block in fault
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_data_reg.ack_accepted |->
            out_data_reg.run_state != hrsd_pkg::ST_FAULT)
        else $error("fault state after accepted acknowledge");

    // Every processed tick leaves boot behind
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> state_reg.current_state != hrsd_pkg::ST_BOOT)
        else $error("still in boot after a tick");

    // A held tick is not dropped while the result side stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("pending tick lost during stall");
`endif

endmodule
